// ----- rtl/yhp_pkg.sv -----
// Shared widths, register indexes and reset values for the yaw-hold PID block.
package yhp_pkg;

  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned GAIN_W    = 28;
  localparam int unsigned KD_W      = 27;
  localparam int unsigned ILIM_W    = 31;
  localparam int unsigned OLIM_W    = 15;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned FRAC_DROP = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KP             = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KI             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RATE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;

  localparam logic [ANGLE_W-1:0] SETPOINT_RST = 16'd0;
  localparam logic [GAIN_W-1:0]  KP_RST       = 28'd983040;
  localparam logic [GAIN_W-1:0]  KI_RST       = 28'd66;
  localparam logic [KD_W-1:0]    KD_RST       = 27'd78643200;
  localparam logic [ILIM_W-1:0]  ILIM_RST     = 31'd1228800000;
  localparam logic [OLIM_W-1:0]  OLIM_RST     = 15'd4800;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [RATE_W-1:0]  rate_t;

endpackage

// ----- rtl/yhp_in_if.sv -----
// Valid/ready channel carrying one yaw sample per transaction.
interface yhp_in_if import yhp_pkg::*; ();
  logic   valid;
  logic   ready;
  angle_t yaw;

  modport source (output valid, output yaw, input ready);
  modport sink   (input valid, input yaw, output ready);
endinterface

// ----- rtl/yhp_out_if.sv -----
// Valid/ready channel carrying one rotation-rate command per transaction.
interface yhp_out_if import yhp_pkg::*; ();
  logic  valid;
  logic  ready;
  rate_t rotation_rate;
  logic  clamped;

  modport source (output valid, output rotation_rate, output clamped, input ready);
  modport sink   (input valid, input rotation_rate, input clamped, output ready);
endinterface

// ----- rtl/yaw_hold_pid_with_clamps.sv -----
// Yaw-hold PID controller with integral and output clamps, four-stage pipeline.
//
// Each yaw sample (Q3.12) produces one rotation-rate command (Q11.4) and a clamp
// flag. Samples pass through four registered stages: input register, error and
// clamped integrator, the three gain products, then sum, floor and output clamp
// into the result register. One transaction is accepted per clock unless the pipeline
// is full and the output is not ready. Each stage advances on its own
// when the next is empty or moving, so a waiting result does not block intake
// until the pipeline is full. The error state and integrator update as a sample
// leaves the input register. Configuration registers take effect for samples
// processed after the write and must be written while the pipeline is empty.
module yaw_hold_pid_with_clamps import yhp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  yhp_in_if.sink                in_if,
  yhp_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ANGLE_W-1:0] setpoint_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  ki_r;
  logic [KD_W-1:0]    kd_r;
  logic [ILIM_W-1:0]  ilim_r;
  logic [OLIM_W-1:0]  olim_r;

  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [SUM_W-1:0] err_sum_r;

  logic v0_r, v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3, adv_out;

  angle_t                  yaw_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DIFF_W-1:0] de_r;
  logic signed [45:0]       p_kp_r;
  logic signed [45:0]       p_kd_r;
  logic signed [60:0]       p_ki_r;
  rate_t                    rate_r;
  logic                     clamp_r;

  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W:0]    lim_s;
  logic signed [SUM_W:0]    lim_neg;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [DIFF_W-1:0] de_nxt;
  logic signed [45:0]       p_kp_nxt;
  logic signed [45:0]       p_kd_nxt;
  logic signed [60:0]       p_ki_nxt;
  logic signed [61:0]       acc;
  logic signed [37:0]       y;
  logic signed [37:0]       olim_s;
  rate_t                    rate_nxt;
  logic                     clamp_nxt;

  assign adv_out = !v3_r || out_if.ready;
  assign adv3    = !v2_r || adv_out;
  assign adv2    = !v1_r || adv3;
  assign adv1    = !v0_r || adv2;

  assign in_if.ready          = adv1;
  assign out_if.valid         = v3_r;
  assign out_if.rotation_rate = rate_r;
  assign out_if.clamped       = clamp_r;

  always_comb begin
    err_nxt = $signed({yaw_r[ANGLE_W-1], yaw_r})
            - $signed({setpoint_r[ANGLE_W-1], setpoint_r});
    sum_raw = $signed({err_sum_r[SUM_W-1], err_sum_r})
            + $signed({{(SUM_W+1-ERR_W){err_nxt[ERR_W-1]}}, err_nxt});
    lim_s   = $signed({2'b00, ilim_r});
    lim_neg = -lim_s;
    if (sum_raw > lim_s) begin
      sum_nxt = lim_s[SUM_W-1:0];
    end else if (sum_raw < lim_neg) begin
      sum_nxt = lim_neg[SUM_W-1:0];
    end else begin
      sum_nxt = sum_raw[SUM_W-1:0];
    end
    de_nxt = $signed({err_nxt[ERR_W-1], err_nxt})
           - $signed({prev_err_r[ERR_W-1], prev_err_r});
  end

  always_comb begin
    p_kp_nxt = $signed({1'b0, kp_r}) * err_r;
    p_kd_nxt = $signed({1'b0, kd_r}) * de_r;
    p_ki_nxt = $signed({1'b0, ki_r}) * sum_r;
  end

  always_comb begin
    acc = $signed({{16{p_kp_r[45]}}, p_kp_r})
        + $signed({{16{p_kd_r[45]}}, p_kd_r})
        + $signed({p_ki_r[60], p_ki_r});
    y         = acc[61:FRAC_DROP];
    olim_s    = $signed({23'd0, olim_r});
    rate_nxt  = y[RATE_W-1:0];
    clamp_nxt = 1'b0;
    if (y > olim_s) begin
      rate_nxt  = olim_s[RATE_W-1:0];
      clamp_nxt = 1'b1;
    end else if (y < -olim_s) begin
      rate_nxt  = 16'(-olim_s);
      clamp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= SETPOINT_RST;
      kp_r       <= KP_RST;
      ki_r       <= KI_RST;
      kd_r       <= KD_RST;
      ilim_r     <= ILIM_RST;
      olim_r     <= OLIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SETPOINT:       setpoint_r <= cfg_wdata[ANGLE_W-1:0];
        REG_KP:             kp_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KI:             ki_r       <= cfg_wdata[GAIN_W-1:0];
        REG_KD_RATE:        kd_r       <= cfg_wdata[KD_W-1:0];
        REG_INTEGRAL_LIMIT: ilim_r     <= cfg_wdata[ILIM_W-1:0];
        REG_OUTPUT_LIMIT:   olim_r     <= cfg_wdata[OLIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r       <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      prev_err_r <= '0;
      err_sum_r  <= '0;
    end else begin
      if (adv1) begin
        v0_r <= in_if.valid;
      end
      if (adv2) begin
        v1_r <= v0_r;
      end
      if (adv3) begin
        v2_r <= v1_r;
      end
      if (adv_out) begin
        v3_r <= v2_r;
      end
      if (v0_r && adv2) begin
        prev_err_r <= err_nxt;
        err_sum_r  <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_if.valid) begin
      yaw_r <= in_if.yaw;
    end
    if (adv2 && v0_r) begin
      err_r <= err_nxt;
      sum_r <= sum_nxt;
      de_r  <= de_nxt;
    end
    if (adv3 && v1_r) begin
      p_kp_r <= p_kp_nxt;
      p_kd_r <= p_kd_nxt;
      p_ki_r <= p_ki_nxt;
    end
    if (adv_out && v2_r) begin
      rate_r  <= rate_nxt;
      clamp_r <= clamp_nxt;
    end
  end

endmodule
